// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sorted value table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define SVT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// check a consequence in the same cycle
`define SVT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// check a consequence in the following cycle
`define SVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/svt_pkg.sv -----
// Package for the sorted value table: field widths, operation and status codes,
// and the control struct between the top level and the head unit. No dependencies.
`default_nettype none

package svt_pkg;

  localparam int VAL_W         = 32;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int DEFAULT_DEPTH = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DEDUPE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic step;
    op_t  op;
    logic desc;
  } head_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/svt_cell.sv -----
// One cell of the sorted value table chain: holds one entry and takes its
// neighbor's entry on each shift. Depends on svt_pkg.
`default_nettype none

module svt_cell (
  input  wire logic                     clk,
  input  wire logic                     shift_en,
  input  wire logic [svt_pkg::VAL_W-1:0] d,
  output logic      [svt_pkg::VAL_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/svt_head.sv -----
// Head unit of the sorted value table chain: looks at the first two cells and
// builds the entry fed back into the tail for insert, delete, dedupe and dump. Depends on svt_pkg.
`default_nettype none

module svt_head #(
  parameter int KW = 4,
  parameter int CW = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire svt_pkg::head_ctrl_t       ctrl,
  input  wire logic [KW-1:0]             k,
  input  wire logic [KW-1:0]             i,
  input  wire logic [CW-1:0]             n,
  input  wire logic [svt_pkg::VAL_W-1:0] v,
  input  wire logic [svt_pkg::VAL_W-1:0] head,
  input  wire logic [svt_pkg::VAL_W-1:0] next,
  output logic      [svt_pkg::VAL_W-1:0] out_data,
  output logic                           found
);

  logic                      placed;
  logic                      skipped;
  logic [svt_pkg::VAL_W-1:0] carry;
  logic [svt_pkg::VAL_W-1:0] key;

  logic                      in_range;
  logic                      at_end;
  logic                      here;
  logic                      ins_at;
  logic                      lo_ok;
  logic                      match;
  logic                      skip_eff;
  logic [svt_pkg::VAL_W-1:0] cmp_val;

  always_comb begin
    in_range = CW'(k) < n;
    at_end   = CW'(k) == n;
    here     = ctrl.desc ? ($signed(head) <= $signed(v)) : ($signed(head) >= $signed(v));
    ins_at   = !placed && (at_end || (in_range && here));
    cmp_val  = (ctrl.op == svt_pkg::OP_DELETE) ? v : key;
    lo_ok    = (ctrl.op == svt_pkg::OP_DELETE) || (k > i);
    match    = !skipped && in_range && lo_ok && (head == cmp_val);
    skip_eff = skipped || match;
    unique case (ctrl.op)
      svt_pkg::OP_INSERT: out_data = placed ? carry : (ins_at ? v : head);
      svt_pkg::OP_DELETE,
      svt_pkg::OP_DEDUPE: out_data = skip_eff ? next : head;
      svt_pkg::OP_DUMP:   out_data = head;
      default:            out_data = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed  <= 1'b0;
      skipped <= 1'b0;
    end else if (ctrl.clear) begin
      placed  <= 1'b0;
      skipped <= 1'b0;
    end else if (ctrl.step) begin
      placed  <= placed || ins_at;
      skipped <= skip_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      carry <= head;
      if (k == i) begin
        key <= head;
      end
    end
  end

  assign found = skipped;

endmodule

`default_nettype wire

// ----- rtl/sorted_value_table.sv -----
// Sorted value table: a ring of TABLE_DEPTH cells rotated once per pass, one request at a time.
// Insert, delete, dedupe pass: a full rotation of the ring, then ST_EVAL, then ST_DONE sends the result.
// Dedupe: a pass per removed copy and per kept entry but the last, each a rotation and an ST_EVAL step.
// Dump: the first entry is registered from the first sweep step, then one entry per cycle unless stalled.
// Full insert, empty dump, dedupe of one entry or fewer: no sweep; the result is sent from ST_DONE.
// Reset: count zero, ascending order; cell contents stay undefined until written.
`default_nettype none
`include "assert_macros.svh"

module sorted_value_table #(
  parameter int TABLE_DEPTH = svt_pkg::DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,    // order_descending
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,        // [31:0] value
  input  wire logic [1:0]  s_tuser,        // [1:0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,        // [31:0] entry_value, [35:32] entry_index,
                                           // [40:36] entry_count, [47:41] zero
  output logic      [1:0]  m_tuser,        // [1:0] status
  output logic             m_tlast         // last
);

  localparam int KW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = svt_pkg::VAL_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [KW-1:0]     k;
  logic [KW-1:0]     i;
  logic [CW-1:0]     count;
  logic              desc;
  svt_pkg::op_t      op_r;
  svt_pkg::status_t  status_r;
  logic [VW-1:0]     v_r;

  logic [VW-1:0]     cell_q [TABLE_DEPTH];
  logic [VW-1:0]     feed;
  logic              found;

  logic              out_free;
  logic              in_range;
  logic              step_en;
  logic              last_step;
  logic              dump_emit;
  logic              launch;
  logic              start_sweep;
  logic [KW-1:0]     i_next;
  logic [CW-1:0]     count_after;
  logic              dd_more;
  svt_pkg::op_t      in_op;
  svt_pkg::head_ctrl_t hctrl;

  always_comb begin
    in_op       = svt_pkg::op_t'(s_tuser);
    s_tready    = (state == ST_IDLE);
    out_free    = !m_tvalid || m_tready;
    in_range    = CW'(k) < count;
    step_en     = (state == ST_SWEEP) &&
                  !((op_r == svt_pkg::OP_DUMP) && in_range && !out_free);
    last_step   = (k == KW'(TABLE_DEPTH - 1));
    dump_emit   = step_en && (op_r == svt_pkg::OP_DUMP) && in_range;
    count_after = count - CW'(found);
    i_next      = found ? i : i + KW'(1);
    dd_more     = (CW'(i_next) + CW'(1)) < count_after;
    unique case (in_op)
      svt_pkg::OP_INSERT: start_sweep = count < CW'(TABLE_DEPTH);
      svt_pkg::OP_DELETE: start_sweep = 1'b1;
      svt_pkg::OP_DEDUPE: start_sweep = count > CW'(1);
      svt_pkg::OP_DUMP:   start_sweep = count != '0;
      default:            start_sweep = 1'b0;
    endcase
    launch      = ((state == ST_IDLE) && s_tvalid && start_sweep) ||
                  ((state == ST_EVAL) && (op_r == svt_pkg::OP_DEDUPE) && dd_more);
    hctrl.clear = launch;
    hctrl.step  = step_en;
    hctrl.op    = op_r;
    hctrl.desc  = desc;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [VW-1:0] d;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign d = feed;
    end else begin : g_body
      assign d = cell_q[g + 1];
    end
    svt_cell u_cell (
      .clk      (clk),
      .shift_en (step_en),
      .d        (d),
      .q        (cell_q[g])
    );
  end

  svt_head #(
    .KW (KW),
    .CW (CW)
  ) u_head (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (hctrl),
    .k        (k),
    .i        (i),
    .n        (count),
    .v        (v_r),
    .head     (cell_q[0]),
    .next     (cell_q[1]),
    .out_data (feed),
    .found    (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      desc <= 1'b0;
    end else if (cfg_wr_en) begin
      desc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      i        <= '0;
      count    <= '0;
      op_r     <= svt_pkg::OP_INSERT;
      status_r <= svt_pkg::STATUS_OK;
      v_r      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r <= in_op;
            v_r  <= s_tdata;
            k    <= '0;
            i    <= '0;
            if (start_sweep) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_DONE;
              unique case (in_op)
                svt_pkg::OP_INSERT: status_r <= svt_pkg::STATUS_FULL;
                svt_pkg::OP_DUMP:   status_r <= svt_pkg::STATUS_EMPTY;
                svt_pkg::OP_DELETE,
                svt_pkg::OP_DEDUPE: status_r <= svt_pkg::STATUS_OK;
                default:            status_r <= svt_pkg::STATUS_OK;
              endcase
            end
          end
        end
        ST_SWEEP: begin
          if (step_en) begin
            if (last_step) begin
              k     <= '0;
              state <= ST_EVAL;
            end else begin
              k <= k + KW'(1);
            end
          end
        end
        ST_EVAL: begin
          unique case (op_r)
            svt_pkg::OP_INSERT: begin
              count    <= count + CW'(1);
              status_r <= svt_pkg::STATUS_OK;
              state    <= ST_DONE;
            end
            svt_pkg::OP_DELETE: begin
              count    <= count_after;
              status_r <= found ? svt_pkg::STATUS_OK : svt_pkg::STATUS_NOT_FOUND;
              state    <= ST_DONE;
            end
            svt_pkg::OP_DEDUPE: begin
              count    <= count_after;
              i        <= i_next;
              status_r <= svt_pkg::STATUS_OK;
              state    <= dd_more ? ST_SWEEP : ST_DONE;
            end
            svt_pkg::OP_DUMP: begin
              state <= ST_IDLE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dump_emit) begin
      m_tvalid <= 1'b1;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dump_emit) begin
      m_tuser <= svt_pkg::STATUS_OK;
      m_tdata <= {7'd0, svt_pkg::CNT_W'(count), svt_pkg::IDX_W'(k), cell_q[0]};
      m_tlast <= (CW'(k) + CW'(1)) == count;
    end else if ((state == ST_DONE) && out_free) begin
      m_tuser <= status_r;
      m_tdata <= {7'd0, svt_pkg::CNT_W'(count), {svt_pkg::IDX_W{1'b0}}, {VW{1'b0}}};
      m_tlast <= 1'b1;
    end
  end

  `SVT_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(TABLE_DEPTH))
  `SVT_ASSERT_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, state != ST_IDLE)
  `SVT_ASSERT_SAME(a_insert_room, clk, rst,
                   (state == ST_EVAL) && (op_r == svt_pkg::OP_INSERT), count < CW'(TABLE_DEPTH))
  `SVT_ASSERT_SAME(a_dedupe_pair, clk, rst,
                   (state == ST_SWEEP) && (op_r == svt_pkg::OP_DEDUPE), (CW'(i) + CW'(1)) < count)
  `SVT_ASSERT_NEXT(a_dump_hold, clk, rst,
                   (state == ST_SWEEP) && (op_r == svt_pkg::OP_DUMP) && m_tvalid && !m_tready &&
                   in_range, $stable(k))

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for sorted_value_table: directed table walk, then random traffic
// in both sort orders, each result compared with an in-bench table predictor or a hand-written one.
// Depends on svt_pkg and the sorted_value_table RTL.
`default_nettype none

module testbench;

  localparam int DEPTH       = svt_pkg::DEFAULT_DEPTH;
  localparam int SETTLE      = DEPTH + 3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 50000;
  localparam int NUM_ROWS    = 25;

  typedef struct packed {
    svt_pkg::status_t          status;
    logic [svt_pkg::VAL_W-1:0] entry_value;
    logic [svt_pkg::IDX_W-1:0] entry_index;
    logic [svt_pkg::CNT_W-1:0] entry_count;
    logic                      last;
  } table_result_t;

  typedef struct packed {
    bit                        set_order;
    bit                        order;
    svt_pkg::op_t              op;
    logic [svt_pkg::VAL_W-1:0] value;
    bit [4:0]                  reps;
    bit                        typed;
    svt_pkg::status_t          status;
    bit [svt_pkg::CNT_W-1:0]   count;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b0, 1'b0, svt_pkg::OP_DUMP,   32'hFFFF_FFFF, 5'd1,  1'b1, svt_pkg::STATUS_EMPTY,     5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DELETE, 32'h0000_0005, 5'd1,  1'b1, svt_pkg::STATUS_NOT_FOUND, 5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DEDUPE, 32'hFFFF_FFFF, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd1},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h8000_0000, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd2},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0000, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd3},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0000, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd4},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'hFFFF_FFFF, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DELETE, 32'h0000_3039, 5'd1,  1'b1, svt_pkg::STATUS_NOT_FOUND, 5'd6},
    '{1'b0, 1'b0, svt_pkg::OP_DELETE, 32'h0000_0000, 5'd1,  1'b1, svt_pkg::STATUS_OK,        5'd5},
    '{1'b0, 1'b0, svt_pkg::OP_DEDUPE, 32'h0000_0000, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DUMP,   32'hFFFF_FFFF, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0007, 5'd12, 1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0001, 5'd1,  1'b1, svt_pkg::STATUS_FULL,      5'd16},
    '{1'b0, 1'b0, svt_pkg::OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DEDUPE, 32'hFFFF_FFFF, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b1, 1'b1, svt_pkg::OP_INSERT, 32'h0000_0000, 5'd0,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0003, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'hAAAA_AAAA, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_INSERT, 32'h5555_5555, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b0, 1'b0, svt_pkg::OP_DELETE, 32'h0000_0007, 5'd1,  1'b0, svt_pkg::STATUS_OK,        5'd0},
    '{1'b1, 1'b0, svt_pkg::OP_INSERT, 32'h0000_0000, 5'd0,  1'b0, svt_pkg::STATUS_OK,        5'd0}
  };

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             s_tvalid    = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata     = '0;
  logic [1:0]       s_tuser     = svt_pkg::OP_INSERT;
  logic             m_tvalid;
  logic             m_tready    = 1'b0;
  logic [47:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;

  logic signed [svt_pkg::VAL_W-1:0] table_entries [DEPTH];
  int                               table_count = 0;
  logic                             table_desc  = 1'b0;
  table_result_t                    pending_results [$];

  bit quiet        = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left    = 0;

  int failures        = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int full_rejects    = 0;
  int delete_misses   = 0;
  int dumps_sent      = 0;
  int orders_set      = 0;

  sorted_value_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void expect_result(svt_pkg::status_t st, logic [svt_pkg::VAL_W-1:0] val,
                                        int idx, int cnt, logic last);
    table_result_t r;
    r.status      = st;
    r.entry_value = val;
    r.entry_index = svt_pkg::IDX_W'(idx);
    r.entry_count = svt_pkg::CNT_W'(cnt);
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  function automatic void remove_entry(int pos);
    for (int i = pos; i + 1 < table_count; i++) table_entries[i] = table_entries[i + 1];
    table_count--;
  endfunction

  function automatic void predict_table_op(svt_pkg::op_t op,
                                           logic signed [svt_pkg::VAL_W-1:0] v);
    int pos;
    int i;
    int j;
    svt_pkg::status_t st;
    st = svt_pkg::STATUS_OK;
    case (op)
      svt_pkg::OP_INSERT: begin
        if (table_count >= DEPTH) begin
          st = svt_pkg::STATUS_FULL;
          full_rejects++;
        end else begin
          pos = table_count;
          for (int k = 0; k < table_count; k++)
            if (pos == table_count &&
                (table_desc ? (table_entries[k] <= v) : (table_entries[k] >= v)))
              pos = k;
          for (int k = table_count; k > pos; k--) table_entries[k] = table_entries[k - 1];
          table_entries[pos] = v;
          table_count++;
        end
        expect_result(st, '0, 0, table_count, 1'b1);
      end
      svt_pkg::OP_DELETE: begin
        pos = -1;
        for (int k = 0; k < table_count; k++)
          if (pos < 0 && table_entries[k] == v) pos = k;
        if (pos < 0) begin
          st = svt_pkg::STATUS_NOT_FOUND;
          delete_misses++;
        end else begin
          remove_entry(pos);
        end
        expect_result(st, '0, 0, table_count, 1'b1);
      end
      svt_pkg::OP_DEDUPE: begin
        i = 0;
        while (i < table_count) begin
          j = i + 1;
          while (j < table_count) begin
            if (table_entries[j] == table_entries[i]) remove_entry(j);
            else j++;
          end
          i++;
        end
        expect_result(svt_pkg::STATUS_OK, '0, 0, table_count, 1'b1);
      end
      default: begin
        dumps_sent++;
        if (table_count == 0) begin
          expect_result(svt_pkg::STATUS_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (int k = 0; k < table_count; k++)
            expect_result(svt_pkg::STATUS_OK, table_entries[k], k, table_count,
                          k + 1 == table_count);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    table_result_t got;
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = svt_pkg::status_t'(m_tuser);
      got.entry_value = m_tdata[31:0];
      got.entry_index = m_tdata[35:32];
      got.entry_count = m_tdata[40:36];
      got.last        = m_tlast;
      results_checked++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d value=%h index=%0d count=%0d last=%0b",
                               got.status, got.entry_value, got.entry_index, got.entry_count,
                               got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.entry_value !== want.entry_value ||
            got.entry_index !== want.entry_index || got.entry_count !== want.entry_count ||
            got.last !== want.last)
          note_failure($sformatf(
            "expected status=%0d value=%h index=%0d count=%0d last=%0b, got %0d %h %0d %0d %0b",
            want.status, want.entry_value, want.entry_index, want.entry_count, want.last,
            got.status, got.entry_value, got.entry_index, got.entry_count, got.last));
      end
    end
  end

  // receiver: random backpressure, or a long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic send_request(svt_pkg::op_t op, logic [svt_pkg::VAL_W-1:0] v);
    while (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_table_op(op, v);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_order(logic d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    table_desc  = d;
    orders_set++;
  endtask

  function automatic logic [svt_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return svt_pkg::VAL_W'($urandom_range(8)) - svt_pkg::VAL_W'(4);
      5: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random_phase(logic order, int n, bit calm, int hold_at, int drain_at);
    int r;
    logic [svt_pkg::VAL_W-1:0] v;
    wait_drained();
    set_order(order);
    quiet = calm;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_pending = 1'b1;
      if (k == drain_at) wait_drained();
      r = $urandom_range(99);
      if (r < 45) begin
        send_request(svt_pkg::OP_INSERT, rand_value());
      end else if (r < 70) begin
        if (table_count > 0 && $urandom_range(9) < 7)
          v = table_entries[$urandom_range(table_count - 1)];
        else
          v = rand_value();
        send_request(svt_pkg::OP_DELETE, v);
      end else if (r < 80) begin
        send_request(svt_pkg::OP_DEDUPE, $urandom());
      end else begin
        send_request(svt_pkg::OP_DUMP, $urandom());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    dir_row_t      row;
    table_result_t typed_result;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_order(1'b0);

    for (int n = 0; n < NUM_ROWS; n++) begin
      row = DIRECTED[n];
      if (row.set_order) begin
        wait_drained();
        set_order(row.order);
      end else begin
        for (int k = 0; k < row.reps; k++) begin
          send_request(row.op, row.value);
          // replace the predicted result with the hand-written one
          if (row.typed) begin
            void'(pending_results.pop_back());
            typed_result = '{row.status, '0, '0, row.count, 1'b1};
            pending_results.push_back(typed_result);
          end
        end
      end
    end

    run_random_phase(1'b1, 87, 1'b0, 10, -1);
    run_random_phase(1'b0, 87, 1'b0, -1, 50);
    run_random_phase(1'b1, 87, 1'b1, -1, -1);
    run_random_phase(1'b0, 87, 1'b0, -1, -1);
    wait_drained();

    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    $display("Sent %0d requests (%0d dumps, %0d full inserts, %0d missed deletes), %0d results",
             requests_sent, dumps_sent, full_rejects, delete_misses, results_checked);
    $display("Order register written %0d times, %0d failures", orders_set, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
